// ----- hw/rtl/ptdt_pkg.sv -----
// Package for the phase-to-depth triangulation unit: payload structs,
// register indexes, reset values and datapath widths. No dependencies.
package ptdt_pkg;

  // Configuration register indexes
  typedef enum logic [3:0] {
    REG_FOCAL_X   = 4'd0,
    REG_FOCAL_Y   = 4'd1,
    REG_CENTER_X  = 4'd2,
    REG_CENTER_Y  = 4'd3,
    REG_COEF_0_4  = 4'd4,
    REG_COEF_1_5  = 4'd5,
    REG_COEF_2_6  = 4'd6,
    REG_COEF_3_7  = 4'd7
  } cfg_reg_e;

  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 64;

  localparam logic [31:0] FocalReset    = 32'h0001_0000;
  localparam logic [31:0] InvalidPhase  = 32'hFFFB_0000;   // -5.0 in Q16.16
  localparam logic [31:0] DepthPosSat   = 32'h7FFF_FFFF;
  localparam logic [31:0] DepthNegSat   = 32'h8000_0000;

  localparam int MaxColumnsDefault = 4096;
  localparam int MaxRowsDefault    = 4096;

  // Datapath widths
  localparam int LinW   = 64;    // c_a*2^16 - c_b*p
  localparam int Prod1W = 96;    // after first 32-bit factor
  localparam int Prod2W = 128;   // after second 32-bit factor
  localparam int DenW   = 130;   // sum of three terms, signed
  localparam int NMagW  = 127;   // numerator magnitude
  localparam int DMagW  = 129;   // denominator magnitude
  localparam int RemW   = NMagW + 16;
  localparam int DivW   = DMagW + 32;
  localparam int QuoW   = 32;

  typedef struct packed {
    logic signed [31:0] phase_value;
    logic        [11:0] pixel_column;
    logic        [11:0] pixel_row;
  } item_t;

  typedef struct packed {
    logic signed [31:0] depth_value;
    logic               divide_fault;
  } result_t;

  // Per-item flags carried through the divider
  typedef struct packed {
    logic inv;
    logic zero;
    logic sat;
    logic neg;
  } flag_t;

endpackage

// ----- hw/rtl/phase_to_depth_triangulation_unit.sv -----
// Phase-to-depth triangulation unit, fully pipelined, one pixel per clock.
// Depends on ptdt_pkg (payload structs, register indexes, widths).
//
//  channel  | signals                          | direction | transfer when
//  ---------+----------------------------------+-----------+--------------------------
//  config   | cfg_we_i, cfg_idx_i, cfg_data_i  | in        | cfg_we_i high at clk edge
//  pixel    | start, busy, item_i              | in        | start high, busy low
//  depth    | result_valid_o, result_o         | out       | every cycle valid is high
//
// A pixel may enter every cycle; busy never rises. The result strobe follows the
// start transfer through 10 arithmetic stages (products, two 32-bit multiply
// rounds split into partial products, sums, magnitudes, range check), then a
// 32-stage restoring divider, one quotient bit per stage, and an output register.
// Reset clears valid bits and configuration registers; the receiver cannot stall.
module phase_to_depth_triangulation_unit #(
  parameter int MAX_COLUMNS = ptdt_pkg::MaxColumnsDefault,
  parameter int MAX_ROWS    = ptdt_pkg::MaxRowsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ptdt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ptdt_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           start,
  output logic                           busy,
  input  ptdt_pkg::item_t                item_i,
  output logic                           result_valid_o,
  output ptdt_pkg::result_t              result_o
);
  import ptdt_pkg::*;

  localparam int NLanes = 4;  // 0: c0/c4 x dx, 1: c1/c5 x dy, 2: c2/c6, 3: c3/c7 numerator

  // ---------------- configuration registers ----------------
  logic [31:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
  logic [63:0] coef_q [NLanes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q  <= FocalReset;
      focal_y_q  <= FocalReset;
      center_x_q <= '0;
      center_y_q <= '0;
      for (int i = 0; i < NLanes; i++) coef_q[i] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FOCAL_X:  focal_x_q  <= cfg_data_i[31:0];
        REG_FOCAL_Y:  focal_y_q  <= cfg_data_i[31:0];
        REG_CENTER_X: center_x_q <= cfg_data_i[31:0];
        REG_CENTER_Y: center_y_q <= cfg_data_i[31:0];
        REG_COEF_0_4: coef_q[0]  <= cfg_data_i;
        REG_COEF_1_5: coef_q[1]  <= cfg_data_i;
        REG_COEF_2_6: coef_q[2]  <= cfg_data_i;
        REG_COEF_3_7: coef_q[3]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;
  logic accept;
  assign accept = start && !busy;

  // ---------------- valid and flag pipe for stages 1..10 ----------------
  localparam int NFront = 10;
  logic       vld_q [NFront+1];
  logic       inv_q [NFront];
  assign vld_q[0] = accept;
  assign inv_q[0] = (item_i.phase_value == InvalidPhase);

  for (genvar s = 1; s <= NFront; s++) begin : g_front_vld
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[s] <= 1'b0;
      else         vld_q[s] <= vld_q[s-1];
    end
    if (s < NFront) begin : g_inv
      always_ff @(posedge clk_i) inv_q[s] <= inv_q[s-1];
    end
  end

  // ---------------- stage 1: c_b * p, pixel offsets ----------------
  logic [11:0] col_cl, row_cl;
  logic [31:0] dx_mag_d, dy_mag_d;
  logic        dx_neg_d, dy_neg_d;
  logic [31:0] colsh, rowsh;

  always_comb begin
    col_cl = ({5'd0, item_i.pixel_column} > 17'(MAX_COLUMNS - 1)) ?
             12'(MAX_COLUMNS - 1) : item_i.pixel_column;
    row_cl = ({5'd0, item_i.pixel_row} > 17'(MAX_ROWS - 1)) ?
             12'(MAX_ROWS - 1) : item_i.pixel_row;
    colsh    = {4'd0, col_cl, 16'd0};
    rowsh    = {4'd0, row_cl, 16'd0};
    dx_neg_d = colsh > center_x_q;
    dy_neg_d = rowsh > center_y_q;
    dx_mag_d = dx_neg_d ? (colsh - center_x_q) : (center_x_q - colsh);
    dy_mag_d = dy_neg_d ? (rowsh - center_y_q) : (center_y_q - rowsh);
  end

  // offsets travel to stage 5 (magnitude) and stage 7 (sign)
  logic [31:0] dx_mag_q [4], dy_mag_q [4];
  logic        dx_neg_q [6], dy_neg_q [6];
  always_ff @(posedge clk_i) begin
    dx_mag_q[0] <= dx_mag_d;
    dy_mag_q[0] <= dy_mag_d;
    dx_neg_q[0] <= dx_neg_d;
    dy_neg_q[0] <= dy_neg_d;
    for (int i = 1; i < 4; i++) begin
      dx_mag_q[i] <= dx_mag_q[i-1];
      dy_mag_q[i] <= dy_mag_q[i-1];
    end
    for (int i = 1; i < 6; i++) begin
      dx_neg_q[i] <= dx_neg_q[i-1];
      dy_neg_q[i] <= dy_neg_q[i-1];
    end
  end

  logic signed [Prod2W-1:0] term_q [NLanes];

  for (genvar l = 0; l < NLanes; l++) begin : g_lane
    logic signed [31:0]       ca, cb;
    logic        [31:0]       k1, k2;
    logic                     negf;
    logic signed [LinW-1:0]   ca_sh;
    logic signed [63:0]       prod_q;
    logic signed [LinW-1:0]   lin_q;
    logic signed [63:0]       hi1_q;
    logic        [63:0]       lo1_q;
    logic        [Prod1W-1:0] t1_q;
    logic signed [63:0]       p2h_q;
    logic        [63:0]       p2m_q, p2l_q;
    logic        [Prod2W-1:0] t2_q;

    assign ca    = coef_q[l][63:32];
    assign cb    = coef_q[l][31:0];
    assign ca_sh = {{16{ca[31]}}, ca, 16'd0};
    assign k1    = (l == 0) ? focal_y_q : focal_x_q;
    assign k2    = (l == 0) ? dx_mag_q[3] : (l == 1) ? dy_mag_q[3] : focal_y_q;
    // offset terms enter negated unless the offset itself is negative
    assign negf  = (l == 0) ? !dx_neg_q[5] : (l == 1) ? !dy_neg_q[5] : 1'b0;

    always_ff @(posedge clk_i) begin
      // stage 1: coefficient times phase
      prod_q <= cb * item_i.phase_value;
      // stage 2: linear term; the numerator lane has the opposite sign
      lin_q  <= (l == 3) ? (prod_q - ca_sh) : (ca_sh - prod_q);
      // stage 3: first factor, two partial products
      hi1_q  <= 64'($signed(lin_q[63:32]) * $signed({1'b0, k1}));
      lo1_q  <= lin_q[31:0] * k1;
      // stage 4: combine
      t1_q   <= {hi1_q[63:0], 32'd0} + {32'd0, lo1_q};
      // stage 5: second factor, three partial products
      p2h_q  <= 64'($signed(t1_q[95:64]) * $signed({1'b0, k2}));
      p2m_q  <= t1_q[63:32] * k2;
      p2l_q  <= t1_q[31:0] * k2;
      // stage 6: combine
      t2_q   <= {p2h_q, 64'd0} + {32'd0, p2m_q, 32'd0} + {64'd0, p2l_q};
      // stage 7: apply sign
      term_q[l] <= negf ? -$signed(t2_q) : $signed(t2_q);
    end
  end

  // ---------------- stage 8: determinant and numerator ----------------
  logic signed [DenW-1:0]   den_q;
  logic signed [Prod2W-1:0] num_q;
  always_ff @(posedge clk_i) begin
    den_q <= DenW'(term_q[0]) + DenW'(term_q[1]) + DenW'(term_q[2]);
    num_q <= term_q[3];
  end

  // ---------------- stage 9: magnitudes ----------------
  logic [NMagW-1:0] nmag_q;
  logic [DMagW-1:0] dmag_q;
  logic             neg9_q, zero9_q;
  always_ff @(posedge clk_i) begin
    neg9_q  <= num_q[Prod2W-1] ^ den_q[DenW-1];
    zero9_q <= (den_q == '0);
    nmag_q  <= num_q[Prod2W-1] ? NMagW'(-num_q) : NMagW'(num_q);
    dmag_q  <= den_q[DenW-1] ? DMagW'(-den_q) : DMagW'(den_q);
  end

  // ---------------- stage 10: range check, divider load ----------------
  localparam int NDiv = QuoW;
  logic [RemW-1:0]  rem_q  [NDiv+1];
  logic [DMagW-1:0] dv_q   [NDiv+1];
  logic [QuoW-1:0]  quo_q  [NDiv+1];
  flag_t            flg_q  [NDiv+1];
  logic             dvld_q [NDiv+1];

  always_ff @(posedge clk_i) begin
    rem_q[0]      <= {nmag_q, 16'd0};
    dv_q[0]       <= dmag_q;
    quo_q[0]      <= '0;
    flg_q[0].inv  <= inv_q[9];
    flg_q[0].zero <= zero9_q;
    flg_q[0].neg  <= neg9_q;
    flg_q[0].sat  <= {18'd0, nmag_q} >= {dmag_q, 16'd0};
  end
  assign dvld_q[0] = vld_q[NFront];

  // ---------------- stages 11..42: restoring divider ----------------
  for (genvar j = 0; j < NDiv; j++) begin : g_div
    localparam int Sh = NDiv - 1 - j;
    logic [DivW-1:0] rx, sx;
    logic            ge;
    assign rx = DivW'(rem_q[j]);
    assign sx = DivW'(dv_q[j]) << Sh;
    assign ge = rx >= sx;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dvld_q[j+1] <= 1'b0;
      else         dvld_q[j+1] <= dvld_q[j];
    end
    always_ff @(posedge clk_i) begin
      rem_q[j+1] <= ge ? RemW'(rx - sx) : rem_q[j];
      dv_q[j+1]  <= dv_q[j];
      quo_q[j+1] <= {quo_q[j][QuoW-2:0], ge};
      flg_q[j+1] <= flg_q[j];
    end
  end

  // ---------------- output register ----------------
  flag_t           fo;
  logic [QuoW-1:0] qo;
  logic [31:0]     depth_d;
  logic            fault_d;

  always_comb begin
    fo      = flg_q[NDiv];
    qo      = quo_q[NDiv];
    fault_d = 1'b0;
    if (fo.inv) begin
      depth_d = '0;
    end else if (fo.zero) begin
      depth_d = '0;
      fault_d = 1'b1;
    end else if (fo.sat || qo[QuoW-1]) begin
      depth_d = (fo.neg && (fo.sat || qo[QuoW-1])) ? DepthNegSat : DepthPosSat;
    end else begin
      depth_d = fo.neg ? (32'd0 - qo) : qo;
    end
  end

  logic    res_vld_q;
  result_t res_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_vld_q <= 1'b0;
    else         res_vld_q <= dvld_q[NDiv];
  end
  always_ff @(posedge clk_i) begin
    res_q.depth_value  <= depth_d;
    res_q.divide_fault <= fault_d;
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

endmodule
